// ===== design/dual_rail_voltage_window_monitor_top_assert.svh =====
// assertion helpers shared by the monitor modules
`ifndef DUAL_RAIL_VOLTAGE_WINDOW_MONITOR_TOP_ASSERT_SVH
`define DUAL_RAIL_VOLTAGE_WINDOW_MONITOR_TOP_ASSERT_SVH

// checked only outside reset
`define DRVWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define DRVWM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/drvwm_pkg.sv =====
`default_nettype none
package drvwm_pkg;

    localparam int WINDOW_LEN_DEF = 10;
    localparam int NUM_RAILS      = 2;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 16;
    localparam int MV_W      = 14;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 8;

    // request kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    // rail codes
    localparam logic RAIL_5V  = 1'b0;
    localparam logic RAIL_12V = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAIL12_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAIL12_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAIL5_HIGH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAIL5_LOW   = 8'd3;

    localparam logic [LIMIT_W-1:0] RAIL12_HIGH_RST = 16'd13000;
    localparam logic [LIMIT_W-1:0] RAIL12_LOW_RST  = 16'd11000;
    localparam logic [LIMIT_W-1:0] RAIL5_HIGH_RST  = 16'd5500;
    localparam logic [LIMIT_W-1:0] RAIL5_LOW_RST   = 16'd4500;

    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic                en;
        logic                channel;
        logic [SAMPLE_W-1:0] data;
    } sample_req_t;

    typedef struct packed {
        logic            valid;
        logic [MV_W-1:0] mv5;
        logic [MV_W-1:0] mv12;
    } mv_res_t;

endpackage
`default_nettype wire

// ===== design/drvwm_ring.sv =====
`default_nettype none
`include "dual_rail_voltage_window_monitor_top_assert.svh"
module drvwm_ring #(
    parameter int WINDOW_LEN = drvwm_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire drvwm_pkg::sample_req_t req,
    output drvwm_pkg::sum_t           rail_sum [drvwm_pkg::NUM_RAILS]
);

    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [drvwm_pkg::SAMPLE_W-1:0] ring_reg [drvwm_pkg::NUM_RAILS][WINDOW_LEN];
    logic [POS_W-1:0]               pos_reg  [drvwm_pkg::NUM_RAILS];
    drvwm_pkg::sum_t                sum_reg  [drvwm_pkg::NUM_RAILS];

    logic [POS_W-1:0]               wr_pos;
    logic [POS_W-1:0]               pos_next;
    logic [drvwm_pkg::SAMPLE_W-1:0] old_sample;
    drvwm_pkg::sum_t                sum_next;

    always_comb begin
        wr_pos     = pos_reg[req.channel];
        old_sample = ring_reg[req.channel][wr_pos];
        // wrap after the last slot
        pos_next   = (wr_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : wr_pos + POS_W'(1);
        sum_next   = sum_reg[req.channel] - drvwm_pkg::SUM_W'(old_sample)
                   + drvwm_pkg::SUM_W'(req.data);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < drvwm_pkg::NUM_RAILS; r++) begin
                pos_reg[r] <= '0;
                sum_reg[r] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    ring_reg[r][i] <= '0;
                end
            end
        end else if (req.en) begin
            ring_reg[req.channel][wr_pos] <= req.data;
            pos_reg[req.channel]          <= pos_next;
            sum_reg[req.channel]          <= sum_next;
        end
    end

    assign rail_sum = sum_reg;

    `DRVWM_ASSERT(a_pos5_range, 32'(pos_reg[0]) < WINDOW_LEN, "5 V ring slot out of range")
    `DRVWM_ASSERT(a_pos12_range, 32'(pos_reg[1]) < WINDOW_LEN, "12 V ring slot out of range")

endmodule
`default_nettype wire

// ===== design/drvwm_scale.sv =====
`default_nettype none
`include "dual_rail_voltage_window_monitor_top_assert.svh"
module drvwm_scale #(
    parameter int WINDOW_LEN = drvwm_pkg::WINDOW_LEN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              check_en,
    input  wire drvwm_pkg::sum_t   rail_sum [drvwm_pkg::NUM_RAILS],
    output logic                   in_ready,
    output drvwm_pkg::mv_res_t     res,
    input  wire logic              res_ready
);

    // sum / WINDOW_LEN as multiply by rounded-up reciprocal, exact for 16-bit sums
    localparam int              DIV_SHIFT = 21;
    localparam int              DIV_MW    = DIV_SHIFT + 1;
    localparam int              DIV_PW    = drvwm_pkg::SUM_W + DIV_MW;
    localparam logic [DIV_MW-1:0] DIV_MULT =
        DIV_MW'(((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    localparam int AVG_W = drvwm_pkg::SAMPLE_W;

    localparam int RAIL5_SCALE  = 825;
    localparam int RAIL5_SHIFT  = 9;
    localparam int RAIL12_SCALE = 10725;
    localparam int RAIL12_SHIFT = 10;
    // x / 3 for x below 2^17
    localparam int DIV3_MULT    = 43691;
    localparam int DIV3_SHIFT   = 17;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   take2, take3, take_out;
    logic [AVG_W-1:0]       avg5_reg, avg12_reg;
    logic [DIV_PW-1:0]      avg5_prod, avg12_prod;
    logic [21:0]            p5;
    logic [25:0]            p12;
    logic [12:0]            mv5_reg2;
    logic [15:0]            x12_reg;
    logic [31:0]            q12;
    logic [drvwm_pkg::MV_W-1:0] mv5_reg3, mv12_reg3;

    assign take_out = v3_reg && res_ready;
    assign take3    = v2_reg && (!v3_reg || take_out);
    assign take2    = v1_reg && (!v2_reg || take3);
    assign in_ready = !v1_reg || take2;

    always_comb begin
        avg5_prod  = DIV_PW'(rail_sum[0]) * DIV_PW'(DIV_MULT);
        avg12_prod = DIV_PW'(rail_sum[1]) * DIV_PW'(DIV_MULT);
        p5         = 22'(avg5_reg) * 22'(RAIL5_SCALE);
        p12        = 26'(avg12_reg) * 26'(RAIL12_SCALE);
        q12        = 32'(x12_reg) * 32'(DIV3_MULT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (check_en)   v1_reg <= 1'b1;
            else if (take2) v1_reg <= 1'b0;
            if (take2)      v2_reg <= 1'b1;
            else if (take3) v2_reg <= 1'b0;
            if (take3)         v3_reg <= 1'b1;
            else if (take_out) v3_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (check_en) begin
            avg5_reg  <= avg5_prod[DIV_SHIFT +: AVG_W];
            avg12_reg <= avg12_prod[DIV_SHIFT +: AVG_W];
        end
        if (take2) begin
            mv5_reg2 <= p5[21:RAIL5_SHIFT];
            x12_reg  <= p12[25:RAIL12_SHIFT];
        end
        if (take3) begin
            mv5_reg3  <= {1'b0, mv5_reg2};
            mv12_reg3 <= q12[DIV3_SHIFT +: drvwm_pkg::MV_W];
        end
    end

    assign res.valid = v3_reg;
    assign res.mv5   = mv5_reg3;
    assign res.mv12  = mv12_reg3;

    `DRVWM_ASSERT(a_stage3_hold, (v3_reg && !res_ready) |=> (v3_reg && $stable(mv12_reg3)), "scaled result lost while stalled")

endmodule
`default_nettype wire

// ===== design/drvwm_check.sv =====
`default_nettype none
`include "dual_rail_voltage_window_monitor_top_assert.svh"
module drvwm_check (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [drvwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [drvwm_pkg::LIMIT_W-1:0]     cfg_data,
    input  wire drvwm_pkg::mv_res_t                res,
    output logic                                   res_ready,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [drvwm_pkg::MV_W-1:0]             m_rail5_mv,
    output logic [drvwm_pkg::MV_W-1:0]             m_rail12_mv,
    output logic                                   m_rail5_fault,
    output logic                                   m_rail12_fault,
    output logic                                   m_rail5_alarm,
    output logic                                   m_rail12_alarm
);

    logic [drvwm_pkg::LIMIT_W-1:0] rail12_high_reg, rail12_low_reg;
    logic [drvwm_pkg::LIMIT_W-1:0] rail5_high_reg, rail5_low_reg;
    logic                          flag5_reg, flag12_reg;
    logic                          m_valid_reg;
    logic                          take;
    logic                          out5, out12;
    logic [drvwm_pkg::LIMIT_W-1:0] mv5_ext, mv12_ext;

    // no register write is taken while reset is held
    assign cfg_ready = aresetn;
    assign res_ready = !m_valid_reg || m_ready;
    assign take      = res.valid && res_ready;

    always_comb begin
        mv5_ext  = drvwm_pkg::LIMIT_W'(res.mv5);
        mv12_ext = drvwm_pkg::LIMIT_W'(res.mv12);
        // low above high leaves no in-window value
        out5  = (mv5_ext > rail5_high_reg) || (mv5_ext < rail5_low_reg);
        out12 = (mv12_ext > rail12_high_reg) || (mv12_ext < rail12_low_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail12_high_reg <= drvwm_pkg::RAIL12_HIGH_RST;
            rail12_low_reg  <= drvwm_pkg::RAIL12_LOW_RST;
            rail5_high_reg  <= drvwm_pkg::RAIL5_HIGH_RST;
            rail5_low_reg   <= drvwm_pkg::RAIL5_LOW_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                drvwm_pkg::REG_RAIL12_HIGH: rail12_high_reg <= cfg_data;
                drvwm_pkg::REG_RAIL12_LOW:  rail12_low_reg  <= cfg_data;
                drvwm_pkg::REG_RAIL5_HIGH:  rail5_high_reg  <= cfg_data;
                drvwm_pkg::REG_RAIL5_LOW:   rail5_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            flag5_reg   <= 1'b0;
            flag12_reg  <= 1'b0;
        end else begin
            if (take) begin
                m_valid_reg <= 1'b1;
                flag5_reg   <= out5;
                flag12_reg  <= out12;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_rail5_mv     <= res.mv5;
            m_rail12_mv    <= res.mv12;
            m_rail5_fault  <= out5;
            m_rail12_fault <= out12;
            m_rail5_alarm  <= out5 && !flag5_reg;
            m_rail12_alarm <= out12 && !flag12_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `DRVWM_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result shown right after reset")
    `DRVWM_ASSERT(a_alarm_fault, (m_valid && (m_rail5_alarm || m_rail12_alarm)) |-> ((!m_rail5_alarm || m_rail5_fault) && (!m_rail12_alarm || m_rail12_fault)), "alarm without fault")

endmodule
`default_nettype wire

// ===== design/dual_rail_voltage_window_monitor_top.sv =====
// path: a check request's result passes the averaging register loaded at acceptance, two
//   scaling stages and the window-compare output register before it is offered
// throughput: one request per cycle while s_ready is high; with the output held, four check
//   results can wait before the input stalls; a sample request gives no result
// reset: synchronous, clears sample rings, sums, slots and fault flags, restores the
//   default limits and holds both ready signals low; no clearing pass follows
`default_nettype none
`include "dual_rail_voltage_window_monitor_top_assert.svh"
module dual_rail_voltage_window_monitor_top #(
    parameter int WINDOW_LEN = drvwm_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic                              s_channel,
    input  wire logic [drvwm_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [drvwm_pkg::MV_W-1:0]             m_rail5_mv,
    output logic [drvwm_pkg::MV_W-1:0]             m_rail12_mv,
    output logic                                   m_rail5_fault,
    output logic                                   m_rail12_fault,
    output logic                                   m_rail5_alarm,
    output logic                                   m_rail12_alarm,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [drvwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [drvwm_pkg::LIMIT_W-1:0]     cfg_data
);

    logic                   accept;
    logic                   check_en;
    logic                   pipe_ready;
    drvwm_pkg::sample_req_t samp_req;
    drvwm_pkg::sum_t        rail_sum [drvwm_pkg::NUM_RAILS];
    drvwm_pkg::mv_res_t     res;
    logic                   res_ready;

    assign s_ready  = pipe_ready && aresetn;
    assign accept   = s_valid && s_ready;
    assign check_en = accept && (s_kind == drvwm_pkg::KIND_CHECK);

    assign samp_req.en      = accept && (s_kind == drvwm_pkg::KIND_SAMPLE);
    assign samp_req.channel = s_channel;
    assign samp_req.data    = s_sample;

    drvwm_ring #(.WINDOW_LEN(WINDOW_LEN)) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (samp_req),
        .rail_sum (rail_sum)
    );

    // a check sees the sums left by every sample accepted before it
    drvwm_scale #(.WINDOW_LEN(WINDOW_LEN)) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .check_en  (check_en),
        .rail_sum  (rail_sum),
        .in_ready  (pipe_ready),
        .res       (res),
        .res_ready (res_ready)
    );

    drvwm_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .res            (res),
        .res_ready      (res_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rail5_mv     (m_rail5_mv),
        .m_rail12_mv    (m_rail12_mv),
        .m_rail5_fault  (m_rail5_fault),
        .m_rail12_fault (m_rail12_fault),
        .m_rail5_alarm  (m_rail5_alarm),
        .m_rail12_alarm (m_rail12_alarm)
    );

    `DRVWM_ASSERT(a_stall_only_when_full, !s_ready |-> (m_valid && !m_ready), "input stalled with room in the pipeline")

endmodule
`default_nettype wire
